// File: rtl/shrd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shrd_pkg: shared definitions for the surplus histogram refine decider
// Widths, register indexes, action codes, state encoding and helpers.
// ---------------------------------------------------------------------------
package shrd_pkg;

   localparam int MAX_BINS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 32;

   localparam int FIELD_BITS     = 32;  // width of the value ports
   localparam int COUNT_BITS     = 32;  // saturating counters
   localparam int BIN_COUNT_BITS = 5;
   localparam int BIN_INDEX_BITS = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int ACTION_BITS    = 2;
   localparam int BIN_COUNT_MIN  = 3;

   // quotient is below bin_count (< 32), so five restoring steps suffice
   localparam int QUO_STEPS  = 5;
   localparam int STEP_BITS  = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [BIN_COUNT_BITS-1:0] BIN_COUNT_RESET = 5'd16;
   localparam logic [COUNT_BITS-1:0]     BUDGET_RESET    = 32'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE           = 3'd0,
      CSR_SMOOTH_COARSE    = 3'd1,
      CSR_REFERENCE_MAX    = 3'd2,
      CSR_ACTION_BUDGET    = 3'd3,
      CSR_BIN_COUNT        = 3'd4,
      CSR_BIN_ACTION_TABLE = 3'd5
   } csr_index_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_NONE   = 2'd0,
      ACT_REFINE = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// File: rtl/surplus_histogram_refine_decider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// surplus_histogram_refine_decider
// Bins a cell's surplus against the reference maximum, updates per-bin
// statistics held in memory and issues the bin's refine/delete action.
// ---------------------------------------------------------------------------
// One request is worked at a time. A request whose surplus falls strictly
// between zero and reference_max passes through acceptance, one decide
// state, five restoring quotient steps for floor(surplus*bins/max), one
// statistics memory read and one write-back before the next acceptance.
// Surplus at zero or at/above the maximum skips the quotient steps;
// blocked, infinite or zero-maximum requests go from decide to finish.
// The result sits in an output register, so the next request is taken
// while it waits; the write-back or finish cycle stalls only when that
// register is still full.
// Statistics reset through per-bin valid bits, no clearing pass.
// Configuration writes are always ready.
// ---------------------------------------------------------------------------
module surplus_histogram_refine_decider #(
   parameter int MAX_BINS   = shrd_pkg::MAX_BINS_DEF,
   parameter int VALUE_BITS = shrd_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [shrd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [shrd_pkg::FIELD_BITS-1:0]       csr_data,
   // request
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [shrd_pkg::FIELD_BITS-1:0]       req_surplus,
   input  logic                                  req_surplus_infinite,
   input  logic [shrd_pkg::FIELD_BITS-1:0]       req_mesh_width,
   input  logic                                  req_cell_refined,
   input  logic                                  req_cell_unrefined,
   // response
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [shrd_pkg::ACTION_BITS-1:0]      rsp_action,
   output logic                                  rsp_bin_hit,
   output logic [shrd_pkg::BIN_INDEX_BITS-1:0]   rsp_bin_index,
   output logic [shrd_pkg::COUNT_BITS-1:0]       rsp_bin_entry_count,
   output logic [shrd_pkg::COUNT_BITS-1:0]       rsp_bin_cancel_count,
   output logic [shrd_pkg::FIELD_BITS-1:0]       rsp_bin_min_width,
   output logic [shrd_pkg::FIELD_BITS-1:0]       rsp_bin_max_width,
   output logic [shrd_pkg::COUNT_BITS-1:0]       rsp_actions_taken,
   output logic [shrd_pkg::COUNT_BITS-1:0]       rsp_evaluations,
   output logic [shrd_pkg::FIELD_BITS-1:0]       rsp_next_reference_max
);

   localparam int VB  = (VALUE_BITS < shrd_pkg::FIELD_BITS) ? VALUE_BITS
                                                            : shrd_pkg::FIELD_BITS;
   localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int PB  = VB + shrd_pkg::BIN_COUNT_BITS;
   localparam int CB  = shrd_pkg::COUNT_BITS;
   localparam int NB  = shrd_pkg::BIN_COUNT_BITS;
   localparam int SB  = shrd_pkg::STEP_BITS;
   localparam int FB  = shrd_pkg::FIELD_BITS;

   // ---------------- configuration registers ----------------
   logic          enable_ff,   enable_in;
   logic          smooth_ff,   smooth_in;
   logic [VB-1:0] ref_max_ff,  ref_max_in;
   logic [CB-1:0] budget_ff,   budget_in;
   logic [NB-1:0] bin_cnt_ff,  bin_cnt_in;
   logic [31:0]   table_ff,    table_in;

   // ---------------- request registers ----------------
   logic [VB-1:0] s_ff,         s_in;
   logic          inf_ff,       inf_in;
   logic [VB-1:0] h_ff,         h_in;
   logic          refined_ff,   refined_in;
   logic          unrefined_ff, unrefined_in;

   // ---------------- binning ----------------
   logic [NB-1:0] bin_ff,  bin_in;
   logic [PB-1:0] rem_ff,  rem_in;
   logic [SB-1:0] step_ff, step_in;

   // ---------------- global state ----------------
   logic [CB-1:0] act_cnt_ff,  act_cnt_in;
   logic [CB-1:0] eval_cnt_ff, eval_cnt_in;
   logic [VB-1:0] run_max_ff,  run_max_in;

   // ---------------- statistics memories ----------------
   logic [2*CB-1:0]     count_mem [MAX_BINS];   // {entry, cancel}
   logic [2*VB-1:0]     width_mem [MAX_BINS];   // {min, max}
   logic [2*CB-1:0]     count_rd_ff;
   logic [2*VB-1:0]     width_rd_ff;
   logic                rd_valid_ff;
   logic [MAX_BINS-1:0] valid_ff, valid_in;

   // ---------------- response registers ----------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_action_ff;
   logic                rsp_hit_ff;
   logic [3:0]          rsp_index_ff;
   logic [CB-1:0]       rsp_entry_ff, rsp_cancel_ff;
   logic [FB-1:0]       rsp_min_ff, rsp_max_ff;
   logic [CB-1:0]       rsp_act_ff, rsp_eval_ff;
   logic [FB-1:0]       rsp_refmax_ff;

   shrd_pkg::state_type state_ff, state_in;

   // ---------------- combinational helpers ----------------
   logic          out_free;
   logic          accept;
   logic          rd_en;
   logic          upd_en;
   logic          fin_en;
   logic [NB-1:0] n_use;
   logic [AW-1:0] addr;
   logic [PB-1:0] m_sh;
   logic          rem_ge;
   logic          s_zero, s_top, ref_zero, unbinned;

   logic [CB-1:0] entry_old, cancel_old, entry_new, cancel_new, eval_new;
   logic [VB-1:0] min_old, max_old, min_new, max_new;
   logic [1:0]    tbl_code;
   logic          over_budget, cancel, issue, smooth_refine;
   logic [1:0]    upd_action;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // bins in use, clamped to [3, MAX_BINS]
   always_comb begin
      if (bin_cnt_ff < NB'(shrd_pkg::BIN_COUNT_MIN)) begin
         n_use = NB'(shrd_pkg::BIN_COUNT_MIN);
      end else if (32'(bin_cnt_ff) > MAX_BINS) begin
         n_use = NB'(MAX_BINS);
      end else begin
         n_use = bin_cnt_ff;
      end
   end

   assign addr     = AW'(bin_ff);
   assign m_sh     = PB'(ref_max_ff) << step_ff;
   assign rem_ge   = rem_ff >= m_sh;
   assign s_zero   = (s_ff == '0);
   assign s_top    = (s_ff >= ref_max_ff);
   assign ref_zero = (ref_max_ff == '0);
   assign unbinned = !enable_ff || inf_ff || ref_zero;
   assign smooth_refine = enable_ff && inf_ff && smooth_ff && unrefined_ff;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shrd_pkg::ST_IDLE: begin
            if (req_valid) state_in = shrd_pkg::ST_DECIDE;
         end
         shrd_pkg::ST_DECIDE: begin
            if (unbinned)             state_in = shrd_pkg::ST_FINISH;
            else if (s_top || s_zero) state_in = shrd_pkg::ST_READ;
            else                      state_in = shrd_pkg::ST_DIVIDE;
         end
         shrd_pkg::ST_DIVIDE: begin
            if (step_ff == '0) state_in = shrd_pkg::ST_READ;
         end
         shrd_pkg::ST_READ: begin
            state_in = shrd_pkg::ST_UPDATE;
         end
         shrd_pkg::ST_UPDATE: begin
            if (out_free) state_in = shrd_pkg::ST_IDLE;
         end
         shrd_pkg::ST_FINISH: begin
            if (out_free) state_in = shrd_pkg::ST_IDLE;
         end
         default: begin
            state_in = shrd_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      upd_en    = 1'b0;
      fin_en    = 1'b0;
      case (state_ff)
         shrd_pkg::ST_IDLE:   req_ready = 1'b1;
         shrd_pkg::ST_READ:   rd_en     = 1'b1;
         shrd_pkg::ST_UPDATE: upd_en    = out_free;
         shrd_pkg::ST_FINISH: fin_en    = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------- configuration writes ----------------
   always_comb begin
      enable_in  = enable_ff;
      smooth_in  = smooth_ff;
      ref_max_in = ref_max_ff;
      budget_in  = budget_ff;
      bin_cnt_in = bin_cnt_ff;
      table_in   = table_ff;
      if (csr_valid) begin
         case (shrd_pkg::csr_index_type'(csr_index))
            shrd_pkg::CSR_ENABLE:           enable_in  = csr_data[0];
            shrd_pkg::CSR_SMOOTH_COARSE:    smooth_in  = csr_data[0];
            shrd_pkg::CSR_REFERENCE_MAX:    ref_max_in = csr_data[VB-1:0];
            shrd_pkg::CSR_ACTION_BUDGET:    budget_in  = csr_data;
            shrd_pkg::CSR_BIN_COUNT:        bin_cnt_in = csr_data[NB-1:0];
            shrd_pkg::CSR_BIN_ACTION_TABLE: table_in   = csr_data;
            default: begin
               enable_in = enable_ff;  // unknown index: ignored
            end
         endcase
      end
   end

   // ---------------- statistics update ----------------
   always_comb begin
      entry_old  = rd_valid_ff ? count_rd_ff[2*CB-1:CB] : '0;
      cancel_old = rd_valid_ff ? count_rd_ff[CB-1:0]    : '0;
      min_old    = rd_valid_ff ? width_rd_ff[2*VB-1:VB] : '1;
      max_old    = rd_valid_ff ? width_rd_ff[VB-1:0]    : '0;

      entry_new = shrd_pkg::sat_inc(entry_old);
      min_new   = (h_ff < min_old) ? h_ff : min_old;
      max_new   = (h_ff > max_old) ? h_ff : max_old;
      eval_new  = shrd_pkg::sat_inc(eval_cnt_ff);

      // table covers bins 0..15 only
      tbl_code    = bin_ff[4] ? 2'b00 : table_ff[{bin_ff[3:0], 1'b0} +: 2];
      over_budget = act_cnt_ff > budget_ff;
      cancel      = 1'b0;
      issue       = 1'b0;
      case (tbl_code)
         shrd_pkg::ACT_REFINE: begin
            cancel = over_budget || !unrefined_ff;
            issue  = !cancel;
         end
         shrd_pkg::ACT_DELETE: begin
            cancel = !refined_ff || over_budget;
            issue  = !cancel;
         end
         default: begin
            cancel = 1'b0;  // none, code 3 acts as none
         end
      endcase
      upd_action = issue ? tbl_code : shrd_pkg::ACT_NONE;
      cancel_new = cancel ? shrd_pkg::sat_inc(cancel_old) : cancel_old;
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      s_in         = s_ff;
      inf_in       = inf_ff;
      h_in         = h_ff;
      refined_in   = refined_ff;
      unrefined_in = unrefined_ff;
      bin_in       = bin_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      run_max_in   = run_max_ff;
      act_cnt_in   = act_cnt_ff;
      eval_cnt_in  = eval_cnt_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         s_in         = req_surplus[VB-1:0];
         inf_in       = req_surplus_infinite;
         h_in         = req_mesh_width[VB-1:0];
         refined_in   = req_cell_refined;
         unrefined_in = req_cell_unrefined;
      end

      if (state_ff == shrd_pkg::ST_DECIDE) begin
         if (enable_ff && !inf_ff && unrefined_ff && (s_ff > run_max_ff)) begin
            run_max_in = s_ff;
         end
         bin_in  = s_top ? (n_use - 1'b1) : '0;
         rem_in  = PB'(s_ff) * PB'(n_use);
         step_in = SB'(shrd_pkg::QUO_STEPS - 1);
      end

      // restoring division of surplus*bins by reference_max
      if (state_ff == shrd_pkg::ST_DIVIDE) begin
         if (rem_ge) begin
            rem_in = rem_ff - m_sh;
            bin_in = bin_ff | (NB'(1) << step_ff);
         end
         step_in = step_ff - 1'b1;
      end

      if (upd_en) begin
         eval_cnt_in    = eval_new;
         valid_in[addr] = 1'b1;
         if (issue) act_cnt_in = shrd_pkg::sat_inc(act_cnt_ff);
         rsp_valid_in   = 1'b1;
      end

      if (fin_en) begin
         if (smooth_refine) act_cnt_in = shrd_pkg::sat_inc(act_cnt_ff);
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shrd_pkg::ST_IDLE;
         enable_ff    <= 1'b1;
         smooth_ff    <= 1'b0;
         ref_max_ff   <= '0;
         budget_ff    <= shrd_pkg::BUDGET_RESET;
         bin_cnt_ff   <= shrd_pkg::BIN_COUNT_RESET;
         table_ff     <= '0;
         act_cnt_ff   <= '0;
         eval_cnt_ff  <= '0;
         run_max_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         smooth_ff    <= smooth_in;
         ref_max_ff   <= ref_max_in;
         budget_ff    <= budget_in;
         bin_cnt_ff   <= bin_cnt_in;
         table_ff     <= table_in;
         act_cnt_ff   <= act_cnt_in;
         eval_cnt_ff  <= eval_cnt_in;
         run_max_ff   <= run_max_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      inf_ff       <= inf_in;
      h_ff         <= h_in;
      refined_ff   <= refined_in;
      unrefined_ff <= unrefined_in;
      bin_ff       <= bin_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
   end

   // Statistics memories. One request is in flight, so the write-back of a
   // bin always lands before the next read; no forwarding is needed.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         count_rd_ff <= count_mem[addr];
         width_rd_ff <= width_mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
      if (upd_en) begin
         count_mem[addr] <= {entry_new, cancel_new};
         width_mem[addr] <= {min_new, max_new};
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (upd_en) begin
         rsp_action_ff <= upd_action;
         rsp_hit_ff    <= 1'b1;
         rsp_index_ff  <= bin_ff[3:0];
         rsp_entry_ff  <= entry_new;
         rsp_cancel_ff <= cancel_new;
         rsp_min_ff    <= FB'(min_new);
         rsp_max_ff    <= FB'(max_new);
         rsp_act_ff    <= act_cnt_in;
         rsp_eval_ff   <= eval_new;
         rsp_refmax_ff <= FB'(run_max_ff);
      end else if (fin_en) begin
         rsp_action_ff <= smooth_refine ? shrd_pkg::ACT_REFINE : shrd_pkg::ACT_NONE;
         rsp_hit_ff    <= 1'b0;
         rsp_index_ff  <= '0;
         rsp_entry_ff  <= '0;
         rsp_cancel_ff <= '0;
         rsp_min_ff    <= '0;
         rsp_max_ff    <= '0;
         rsp_act_ff    <= act_cnt_in;
         rsp_eval_ff   <= eval_cnt_ff;
         rsp_refmax_ff <= FB'(run_max_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_action             = rsp_action_ff;
   assign rsp_bin_hit            = rsp_hit_ff;
   assign rsp_bin_index          = rsp_index_ff;
   assign rsp_bin_entry_count    = rsp_entry_ff;
   assign rsp_bin_cancel_count   = rsp_cancel_ff;
   assign rsp_bin_min_width      = rsp_min_ff;
   assign rsp_bin_max_width      = rsp_max_ff;
   assign rsp_actions_taken      = rsp_act_ff;
   assign rsp_evaluations        = rsp_eval_ff;
   assign rsp_next_reference_max = rsp_refmax_ff;

endmodule
